FILE: rtl/mmc_pkg.sv
// shared constants, types and codes for the magnetometer min/max calibration block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package mmc_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int SCALE_FRAC_BITS = 16;
    localparam int SCALE_INT_BITS  = 8;
    localparam int GAIN_BITS       = 16;
    localparam int AXES            = 3;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(39322);

    localparam int OFFSET_W = SAMPLE_BITS + 1;
    localparam int SPAN_W   = SAMPLE_BITS;
    localparam int SUM_W    = SAMPLE_BITS + 2;
    localparam int PROD_W   = GAIN_BITS + SUM_W;
    localparam int SCALE_W  = SCALE_INT_BITS + SCALE_FRAC_BITS;
    localparam int DEN_W    = SUM_W;

    // numerator gets extra fraction bits, or the quotient drops some
    localparam int FRAC_SHIFT = (SCALE_FRAC_BITS >= GAIN_BITS) ? SCALE_FRAC_BITS - GAIN_BITS : 0;
    localparam int Q_SHIFT    = (GAIN_BITS > SCALE_FRAC_BITS) ? GAIN_BITS - SCALE_FRAC_BITS : 0;
    localparam int NUM_W      = PROD_W + FRAC_SHIFT;
    localparam int CMP_W      = (NUM_W > SCALE_W) ? NUM_W : SCALE_W;

    localparam logic [SCALE_W-1:0]     SCALE_TOP     = '1;
    localparam logic [SAMPLE_BITS-1:0] TRK_MAX_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] TRK_MIN_RESET = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    localparam int IN_W  = ((AXES * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 + AXES * OFFSET_W + AXES * SCALE_W;
    localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_SPAN_ZERO  = 2'd1;
    localparam logic [1:0] ST_NO_SAMPLES = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef struct packed {
        logic load;
        logic shift;
        logic msb;
        logic update;
        logic clear;
    } trk_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/magnetometer_minmax_calibration_top.sv
// magnetometer min/max calibration: a sample item is accepted, compared
// bit-serially with the trackers, then applied; a finish item with samples
// runs a serial multiply, then a serial divide per axis of nonzero span; a
// finish without samples goes straight to emit; input taken one item at a time
// result held in an output register, so the next item is taken while it waits
// reset (rst_n low, async): trackers to the int extremes, no samples, gain 0.6
// depends on mmc_pkg, mmc_tracker, mmc_serial_mult, mmc_serial_div
`timescale 1ns / 1ps
`default_nettype none

module magnetometer_minmax_calibration_top
    import mmc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // config: scale_gain, unsigned Q0.16
    input  wire logic                 cfg_we,
    input  wire logic [GAIN_BITS-1:0] cfg_wdata,
    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_W-1:0]      s_tdata,   // mag_x, mag_y, mag_z
    input  wire logic                 s_tuser,   // kind: 0 sample, 1 finish
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // status, offset_x, offset_y, offset_z, scale_x, scale_y, scale_z, zero pad
    output logic      [OUT_W-1:0]     m_tdata
);

    localparam int BIT_CNT_W = $clog2(SAMPLE_BITS);
    localparam int AXIS_W    = $clog2(AXES);

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_TRACK  = 8'b0000_0010,
        S_UPDATE = 8'b0000_0100,
        S_SUM    = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_AXIS   = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [AXIS_W-1:0]      axis_reg, axis_next;
    logic                   seen_reg, seen_next;
    logic [GAIN_BITS-1:0]   gain_reg, gain_next;
    logic [1:0]             status_reg, status_next;
    logic [OFFSET_W-1:0]    off_reg [AXES];
    logic [OFFSET_W-1:0]    off_next [AXES];
    logic [SPAN_W-1:0]      span_reg [AXES];
    logic [SPAN_W-1:0]      span_next [AXES];
    logic [SCALE_W-1:0]     scale_reg [AXES];
    logic [SCALE_W-1:0]     scale_next [AXES];
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;

    trk_ctrl_t              trk_ctrl;
    logic [SAMPLE_BITS-1:0] trk_max [AXES];
    logic [SAMPLE_BITS-1:0] trk_min [AXES];

    logic                   in_accept;
    logic                   out_free;
    logic                   mul_start, mul_done;
    logic [PROD_W-1:0]      product;
    logic [SUM_W-1:0]       span_sum;
    logic                   div_start, div_done;
    logic [DEN_W-1:0]       div_den;
    logic [SCALE_W-1:0]     div_quot;
    logic [SPAN_W-1:0]      span_sel;
    logic                   last_axis;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // one bit-serial tracker per axis
    for (genvar g = 0; g < AXES; g++)
    begin : g_trk
        mmc_tracker u_trk (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (trk_ctrl),
            .sample  (s_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .max_val (trk_max[g]),
            .min_val (trk_min[g])
        );
    end

    // gain * (span_x + span_y + span_z)
    assign span_sum = SUM_W'(span_reg[0]) + SUM_W'(span_reg[1]) + SUM_W'(span_reg[2]);

    mmc_serial_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mul_a   (gain_reg),
        .mul_b   (span_sum),
        .done    (mul_done),
        .product (product)
    );

    // divisor 3 * span of the current axis
    assign span_sel  = span_reg[axis_reg];
    assign div_den   = DEN_W'(span_sel) + (DEN_W'(span_sel) << 1);
    assign last_axis = (axis_reg == AXIS_W'(AXES - 1));

    mmc_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (product),
        .denom (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // config register
    assign gain_next = cfg_we ? cfg_wdata : gain_reg;

    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        axis_next      = axis_reg;
        seen_next      = seen_reg;
        status_next    = status_reg;
        off_next       = off_reg;
        span_next      = span_reg;
        scale_next     = scale_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        trk_ctrl       = '0;
        mul_start      = 1'b0;
        div_start      = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser == KIND_SAMPLE)
                    begin
                        trk_ctrl.load = 1'b1;
                        seen_next     = 1'b1;
                        bit_cnt_next  = '0;
                        state_next    = S_TRACK;
                    end
                    else
                    begin
                        // finish: clear the trackers; with samples, grab offsets and spans
                        trk_ctrl.clear = 1'b1;
                        seen_next      = 1'b0;
                        if (seen_reg)
                        begin
                            status_next = ST_OK;
                            for (int i = 0; i < AXES; i++)
                            begin
                                off_next[i]  = {trk_max[i][SAMPLE_BITS-1], trk_max[i]}
                                             + {trk_min[i][SAMPLE_BITS-1], trk_min[i]};
                                span_next[i] = SPAN_W'(trk_max[i] - trk_min[i]);
                            end
                            state_next = S_SUM;
                        end
                        else
                        begin
                            // no samples since the last finish: offsets and scales zero
                            status_next = ST_NO_SAMPLES;
                            for (int i = 0; i < AXES; i++)
                            begin
                                off_next[i]   = '0;
                                scale_next[i] = '0;
                            end
                            state_next = S_EMIT;
                        end
                    end
                end
            end

            S_TRACK:
            begin
                trk_ctrl.shift = 1'b1;
                trk_ctrl.msb   = (bit_cnt_reg == BIT_CNT_W'(SAMPLE_BITS - 1));
                bit_cnt_next   = bit_cnt_reg + 1'b1;
                if (trk_ctrl.msb)
                begin
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                trk_ctrl.update = 1'b1;
                state_next      = S_IDLE;
            end

            S_SUM:
            begin
                mul_start  = 1'b1;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                if (mul_done)
                begin
                    axis_next  = '0;
                    state_next = S_AXIS;
                end
            end

            S_AXIS:
            begin
                if (span_sel == '0)
                begin
                    // zero span: scale pegged, flag it
                    scale_next[axis_reg] = SCALE_TOP;
                    status_next          = ST_SPAN_ZERO;
                    axis_next            = axis_reg + 1'b1;
                    if (last_axis)
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    scale_next[axis_reg] = div_quot;
                    axis_next            = axis_reg + 1'b1;
                    state_next           = last_axis ? S_EMIT : S_AXIS;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'({scale_reg[2], scale_reg[1], scale_reg[0],
                                             off_reg[2], off_reg[1], off_reg[0],
                                             status_reg});
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_cnt_reg   <= '0;
            axis_reg      <= '0;
            seen_reg      <= 1'b0;
            gain_reg      <= GAIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            axis_reg      <= axis_next;
            seen_reg      <= seen_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        off_reg      <= off_next;
        span_reg     <= span_next;
        scale_reg    <= scale_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: rtl/mmc_tracker.sv
// bit-serial running max/min tracker for one axis
// depends on mmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mmc_tracker
    import mmc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire trk_ctrl_t              ctrl,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output logic      [SAMPLE_BITS-1:0] max_val,
    output logic      [SAMPLE_BITS-1:0] min_val
);

    logic [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic                   gt_reg, gt_next;
    logic                   lt_reg, lt_next;
    logic                   a_bit, b_bit, c_bit;

    // sign bit flipped so signed order becomes unsigned order
    assign a_bit = smp_reg[0] ^ ctrl.msb;
    assign b_bit = max_reg[0] ^ ctrl.msb;
    assign c_bit = min_reg[0] ^ ctrl.msb;

    always_comb
    begin
        smp_next = smp_reg;
        max_next = max_reg;
        min_next = min_reg;
        gt_next  = gt_reg;
        lt_next  = lt_reg;
        if (ctrl.clear)
        begin
            max_next = TRK_MAX_RESET;
            min_next = TRK_MIN_RESET;
        end
        else if (ctrl.load)
        begin
            smp_next = sample;
            gt_next  = 1'b0;
            lt_next  = 1'b0;
        end
        else if (ctrl.shift)
        begin
            // lsb first: the highest differing bit decides
            smp_next = {smp_reg[0], smp_reg[SAMPLE_BITS-1:1]};
            max_next = {max_reg[0], max_reg[SAMPLE_BITS-1:1]};
            min_next = {min_reg[0], min_reg[SAMPLE_BITS-1:1]};
            if (a_bit != b_bit)
            begin
                gt_next = a_bit;
            end
            if (a_bit != c_bit)
            begin
                lt_next = c_bit;
            end
        end
        else if (ctrl.update)
        begin
            if (gt_reg)
            begin
                max_next = smp_reg;
            end
            if (lt_reg)
            begin
                min_next = smp_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= TRK_MAX_RESET;
            min_reg <= TRK_MIN_RESET;
            gt_reg  <= 1'b0;
            lt_reg  <= 1'b0;
        end
        else
        begin
            max_reg <= max_next;
            min_reg <= min_next;
            gt_reg  <= gt_next;
            lt_reg  <= lt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
    end

    assign max_val = max_reg;
    assign min_val = min_reg;

endmodule

`default_nettype wire

FILE: rtl/mmc_serial_mult.sv
// shift-add multiplier, one multiplier bit per cycle
// depends on mmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mmc_serial_mult
    import mmc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [GAIN_BITS-1:0] mul_a,
    input  wire logic [SUM_W-1:0]     mul_b,
    output logic                      done,
    output logic      [PROD_W-1:0]    product
);

    localparam int CNT_W = $clog2(GAIN_BITS);

    logic [PROD_W-1:0] p_reg, p_next;
    logic [SUM_W-1:0]  b_reg, b_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SUM_W:0]    upper;

    assign upper = {1'b0, p_reg[PROD_W-1:GAIN_BITS]}
                 + (p_reg[0] ? {1'b0, b_reg} : {(SUM_W+1){1'b0}});

    always_comb
    begin
        p_next    = p_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            p_next    = PROD_W'(mul_a);
            b_next    = mul_b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            p_next   = {upper, p_reg[GAIN_BITS-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(GAIN_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        b_reg <= b_next;
    end

    assign done    = done_reg;
    assign product = p_reg;

endmodule

`default_nettype wire

FILE: rtl/mmc_serial_div.sv
// restoring divider, one quotient bit per cycle, saturating scale result
// depends on mmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mmc_serial_div
    import mmc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] numer,
    input  wire logic [DEN_W-1:0]  denom,
    output logic                   done,
    output logic      [SCALE_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] n_reg, n_next;
    logic [DEN_W-1:0] r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [NUM_W-1:0] q_sh;
    logic [CMP_W-1:0] q_wide;

    assign trial = {r_reg, n_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = (trial >= {1'b0, d_reg});

    always_comb
    begin
        n_next    = n_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = NUM_W'(numer) << FRAC_SHIFT;
            r_next    = '0;
            d_next    = denom;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_next   = {n_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    // saturate to the all-ones scale code
    assign q_sh   = n_reg >> Q_SHIFT;
    assign q_wide = CMP_W'(q_sh);
    assign quot   = (q_wide > CMP_W'(SCALE_TOP)) ? SCALE_TOP : q_wide[SCALE_W-1:0];
    assign done   = done_reg;

endmodule

`default_nettype wire
